FILE: hdl/prc_pkg.sv
package prc_pkg;

    // Opcodes of an input transaction.
    localparam logic [2:0] OP_CLASSIFY_IN  = 3'd0;
    localparam logic [2:0] OP_CLASSIFY_OUT = 3'd1;
    localparam logic [2:0] OP_WRITE_SVC    = 3'd2;
    localparam logic [2:0] OP_WRITE_HOST   = 3'd3;
    localparam logic [2:0] OP_CLEAR        = 3'd4;

    // Rule classes.
    localparam logic [1:0] CLS_ALLOW   = 2'd0;
    localparam logic [1:0] CLS_WARNING = 2'd1;
    localparam logic [1:0] CLS_ALERT   = 2'd2;
    localparam logic [1:0] CLS_DENY    = 2'd3;

    // Verdict codes.
    localparam logic [1:0] VERD_DROP    = 2'd0;
    localparam logic [1:0] VERD_ALLOW   = 2'd1;
    localparam logic [1:0] VERD_WARNING = 2'd2;
    localparam logic [1:0] VERD_ALERT   = 2'd3;

    // Address width and the longest prefix.
    localparam int          ADDR_BITS = 32;
    localparam logic [5:0]  PLEN_MAX  = 6'd32;
    localparam logic [31:0] ADDR_ONES = 32'hFFFFFFFF;

    // Kind of work that the back end carries out for one transaction.
    typedef enum logic [2:0] {
        K_NOP,
        K_CLS_IN,
        K_CLS_OUT,
        K_WR_SVC,
        K_WR_HOST,
        K_CLEAR
    } t_kind;

    // Decoded command passed from the front end through the queue.
    typedef struct packed {
        t_kind       kind;
        logic        wr_ok;
        logic [5:0]  entry_index;
        logic        rule_valid;
        logic [1:0]  rule_class;
        logic        rule_outgoing;
        logic [7:0]  protocol;
        logic [15:0] port;
        logic [15:0] port_high;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic        no_ports;
    } t_cmd;

    // Service rule entry, 44 bits.
    typedef struct packed {
        logic        valid;
        logic        outgoing;
        logic [1:0]  cls;
        logic [7:0]  proto;
        logic [15:0] lo;
        logic [15:0] hi;
    } t_svc_entry;

    // Host rule entry, 41 bits.
    typedef struct packed {
        logic        valid;
        logic [1:0]  cls;
        logic [31:0] address;
        logic [5:0]  plen;
    } t_host_entry;

endpackage

FILE: hdl/prc_front.sv
module prc_front #(
    parameter int SERVICE_ENTRIES = 64,
    parameter int HOST_ENTRIES    = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_opcode,
    input  logic [5:0]          i_entry_index,
    input  logic                i_rule_valid,
    input  logic [1:0]          i_rule_class,
    input  logic                i_rule_outgoing,
    input  logic [7:0]          i_protocol,
    input  logic [15:0]         i_port,
    input  logic [15:0]         i_port_high,
    input  logic [31:0]         i_address,
    input  logic [5:0]          i_prefix_len,
    input  logic                i_no_ports,
    input  logic                i_back_init,
    input  logic                i_q_full,
    output logic                o_push,
    output prc_pkg::t_cmd       o_cmd
);

    logic          r_cmd_vld;
    prc_pkg::t_cmd r_cmd;
    prc_pkg::t_cmd n_cmd;
    logic          accept;

    // The front stage stalls when its command cannot enter the queue, and while the
    // back end clears its tables after reset.
    assign busy   = (r_cmd_vld && i_q_full) || i_back_init;
    assign accept = start && !busy;
    assign o_push = r_cmd_vld && !i_q_full;
    assign o_cmd  = r_cmd;

    // Decode the opcode, check the write index against the table depth and clamp the prefix.
    always_comb begin
        n_cmd               = '0;
        n_cmd.entry_index   = i_entry_index;
        n_cmd.rule_valid    = i_rule_valid;
        n_cmd.rule_class    = i_rule_class;
        n_cmd.rule_outgoing = i_rule_outgoing;
        n_cmd.protocol      = i_protocol;
        n_cmd.port          = i_port;
        n_cmd.port_high     = i_port_high;
        n_cmd.address       = i_address;
        n_cmd.no_ports      = i_no_ports;
        n_cmd.prefix_len    = (i_prefix_len > prc_pkg::PLEN_MAX) ? prc_pkg::PLEN_MAX
                                                                  : i_prefix_len;
        unique case (i_opcode)
            prc_pkg::OP_CLASSIFY_IN: begin
                n_cmd.kind = prc_pkg::K_CLS_IN;
            end
            prc_pkg::OP_CLASSIFY_OUT: begin
                n_cmd.kind = prc_pkg::K_CLS_OUT;
            end
            prc_pkg::OP_WRITE_SVC: begin
                n_cmd.kind  = prc_pkg::K_WR_SVC;
                n_cmd.wr_ok = 32'(i_entry_index) < SERVICE_ENTRIES;
            end
            prc_pkg::OP_WRITE_HOST: begin
                n_cmd.kind  = prc_pkg::K_WR_HOST;
                n_cmd.wr_ok = 32'(i_entry_index) < HOST_ENTRIES;
            end
            prc_pkg::OP_CLEAR: begin
                n_cmd.kind = prc_pkg::K_CLEAR;
            end
            default: begin
                n_cmd.kind = prc_pkg::K_NOP;
            end
        endcase
    end

    // Command register in front of the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_cmd_vld <= 1'b1;
            end else if (o_push) begin
                r_cmd_vld <= 1'b0;
            end
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: hdl/prc_cmd_queue.sv
module prc_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  prc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_not_empty,
    output prc_pkg::t_cmd o_cmd
);

    prc_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_full      = r_count == 2'd2;
    assign o_not_empty = r_count != 2'd0;
    assign o_cmd       = r_slot[r_rd_ptr];

    // Two-entry queue between the front and back ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: hdl/prc_back.sv
module prc_back #(
    parameter int SERVICE_ENTRIES = 64,
    parameter int HOST_ENTRIES    = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_vld,
    input  prc_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_init,
    output logic          o_done,
    output logic [1:0]    o_verdict
);

    localparam int MAXD = (SERVICE_ENTRIES > HOST_ENTRIES) ? SERVICE_ENTRIES : HOST_ENTRIES;
    localparam int CW   = $clog2(MAXD);
    localparam int SAW  = $clog2(SERVICE_ENTRIES);
    localparam int HAW  = $clog2(HOST_ENTRIES);
    localparam int IW0  = (SAW > HAW) ? SAW : HAW;
    localparam int IW   = (IW0 > 6) ? IW0 : 6;
    localparam logic [CW-1:0] LAST = CW'(MAXD - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_DRAIN,
        S_FINAL
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_cnt;
    prc_pkg::t_cmd         r_op;
    logic                  r_rd_vld;
    logic                  r_rd_svc_ok;
    logic                  r_rd_host_ok;
    logic [3:0]            r_svc_hit;
    logic [3:0]            r_host_hit;
    logic                  r_done;
    logic [1:0]            r_verdict;

    prc_pkg::t_svc_entry   svc_mem [SERVICE_ENTRIES];
    prc_pkg::t_host_entry  host_mem [HOST_ENTRIES];
    prc_pkg::t_svc_entry   r_svc_rd;
    prc_pkg::t_host_entry  r_host_rd;

    logic                  pop;
    logic                  cnt_last;
    logic                  cnt_svc_in;
    logic                  cnt_host_in;
    logic                  sweeping;
    logic [IW-1:0]         idx_w;
    logic                  svc_we;
    logic [SAW-1:0]        svc_wa;
    prc_pkg::t_svc_entry   svc_wd;
    logic                  host_we;
    logic [HAW-1:0]        host_wa;
    prc_pkg::t_host_entry  host_wd;
    logic                  want_out;
    logic                  svc_match;
    logic                  host_match;
    logic [31:0]           host_mask;
    logic [3:0]            n_svc_hit;
    logic [3:0]            n_host_hit;
    logic [1:0]            final_verdict;

    // Deny gives drop; otherwise allow, then warning, then alert.
    function automatic logic [1:0] grade_last_wins(input logic [3:0] hit);
        logic [1:0] g;
        if (hit[prc_pkg::CLS_DENY]) begin
            g = prc_pkg::VERD_DROP;
        end else if (hit[prc_pkg::CLS_ALLOW]) begin
            g = prc_pkg::VERD_ALLOW;
        end else if (hit[prc_pkg::CLS_WARNING]) begin
            g = prc_pkg::VERD_WARNING;
        end else if (hit[prc_pkg::CLS_ALERT]) begin
            g = prc_pkg::VERD_ALERT;
        end else begin
            g = prc_pkg::VERD_DROP;
        end
        return g;
    endfunction

    assign pop         = (r_state == S_IDLE) && i_cmd_vld;
    assign o_pop       = pop;
    assign o_init      = r_state == S_INIT;
    assign o_done      = r_done;
    assign o_verdict   = r_verdict;
    assign cnt_last    = r_cnt == LAST;
    assign cnt_svc_in  = {1'b0, r_cnt} < (CW + 1)'(SERVICE_ENTRIES);
    assign cnt_host_in = {1'b0, r_cnt} < (CW + 1)'(HOST_ENTRIES);
    assign sweeping    = (r_state == S_INIT) || (r_state == S_CLEAR);
    assign idx_w       = IW'(i_cmd.entry_index);

    // Write ports: the clearing sweep or a rule write taken from the queue.
    always_comb begin
        svc_we           = 1'b0;
        svc_wa           = idx_w[SAW-1:0];
        svc_wd.valid     = i_cmd.rule_valid;
        svc_wd.outgoing  = i_cmd.rule_outgoing;
        svc_wd.cls       = i_cmd.rule_class;
        svc_wd.proto     = i_cmd.protocol;
        svc_wd.lo        = i_cmd.port;
        svc_wd.hi        = i_cmd.port_high;
        host_we          = 1'b0;
        host_wa          = idx_w[HAW-1:0];
        host_wd.valid    = i_cmd.rule_valid;
        host_wd.cls      = i_cmd.rule_class;
        host_wd.address  = i_cmd.address;
        host_wd.plen     = i_cmd.prefix_len;
        if (sweeping) begin
            svc_we  = cnt_svc_in;
            svc_wa  = r_cnt[SAW-1:0];
            svc_wd  = '0;
            host_we = cnt_host_in;
            host_wa = r_cnt[HAW-1:0];
            host_wd = '0;
        end else if (pop && i_cmd.wr_ok) begin
            svc_we  = i_cmd.kind == prc_pkg::K_WR_SVC;
            host_we = i_cmd.kind == prc_pkg::K_WR_HOST;
        end
    end

    // Rule memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (svc_we) begin
            svc_mem[svc_wa] <= svc_wd;
        end
        r_svc_rd <= svc_mem[r_cnt[SAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (host_we) begin
            host_mem[host_wa] <= host_wd;
        end
        r_host_rd <= host_mem[r_cnt[HAW-1:0]];
    end

    // Compare the entries just read against the packet being classified.
    always_comb begin
        want_out   = r_op.kind == prc_pkg::K_CLS_OUT;
        host_mask  = ~(prc_pkg::ADDR_ONES >> r_host_rd.plen);
        svc_match  = r_rd_vld && r_rd_svc_ok && r_svc_rd.valid &&
                     (r_svc_rd.outgoing == want_out) &&
                     (r_svc_rd.proto == r_op.protocol) &&
                     (r_op.port >= r_svc_rd.lo) && (r_op.port <= r_svc_rd.hi);
        host_match = r_rd_vld && r_rd_host_ok && r_host_rd.valid &&
                     (((r_op.address ^ r_host_rd.address) & host_mask) == '0);
        n_svc_hit  = r_svc_hit | (svc_match ? (4'b0001 << r_svc_rd.cls) : 4'b0000);
        n_host_hit = r_host_hit | (host_match ? (4'b0001 << r_host_rd.cls) : 4'b0000);
    end

    // Combine the collected hits into a verdict.
    always_comb begin
        logic [1:0] hg;
        logic [1:0] sg;
        hg = grade_last_wins(r_host_hit);
        sg = grade_last_wins(r_svc_hit);
        if (!want_out) begin
            if (r_svc_hit[prc_pkg::CLS_DENY]) begin
                final_verdict = prc_pkg::VERD_DROP;
            end else if (r_svc_hit[prc_pkg::CLS_ALERT]) begin
                final_verdict = prc_pkg::VERD_ALERT;
            end else if (r_svc_hit[prc_pkg::CLS_WARNING]) begin
                final_verdict = prc_pkg::VERD_WARNING;
            end else if (r_svc_hit[prc_pkg::CLS_ALLOW]) begin
                final_verdict = prc_pkg::VERD_ALLOW;
            end else begin
                final_verdict = prc_pkg::VERD_DROP;
            end
        end else if (r_host_hit[prc_pkg::CLS_DENY] || r_op.no_ports) begin
            final_verdict = hg;
        end else if ((hg == prc_pkg::VERD_DROP) || (sg == prc_pkg::VERD_DROP)) begin
            final_verdict = prc_pkg::VERD_DROP;
        end else begin
            final_verdict = (hg > sg) ? hg : sg;
        end
    end

    // Sequencer: clearing sweeps, table scans and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_svc_hit  <= '0;
            r_host_hit <= '0;
            r_done     <= 1'b0;
            r_verdict  <= prc_pkg::VERD_DROP;
        end else begin
            r_done       <= 1'b0;
            r_rd_vld     <= r_state == S_SCAN;
            r_rd_svc_ok  <= cnt_svc_in;
            r_rd_host_ok <= cnt_host_in;
            r_svc_hit    <= n_svc_hit;
            r_host_hit   <= n_host_hit;
            unique case (r_state)
                S_INIT: begin
                    if (cnt_last) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_IDLE: begin
                    if (pop) begin
                        r_op       <= i_cmd;
                        r_cnt      <= '0;
                        r_svc_hit  <= '0;
                        r_host_hit <= '0;
                        unique case (i_cmd.kind) inside
                            prc_pkg::K_CLS_IN, prc_pkg::K_CLS_OUT: begin
                                r_state <= S_SCAN;
                            end
                            prc_pkg::K_CLEAR: begin
                                r_state <= S_CLEAR;
                            end
                            default: begin
                                r_done    <= 1'b1;
                                r_verdict <= prc_pkg::VERD_DROP;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    if (cnt_last) begin
                        r_cnt     <= '0;
                        r_done    <= 1'b1;
                        r_verdict <= prc_pkg::VERD_DROP;
                        r_state   <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_SCAN: begin
                    if (cnt_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINAL;
                end
                S_FINAL: begin
                    r_done    <= 1'b1;
                    r_verdict <= final_verdict;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/packet_rule_classifier.sv
// A write or unused opcode passes the front command register and the queue, then the back end
// registers its verdict strobe on taking the command; a classify or clear first sweeps both rule memories.
// The back end takes no new command until it has finished the last one, as it scans both rule
// memories one entry a cycle; writes complete one per cycle while the back end is idle.
// Reset: synchronous, active low; afterwards a clearing pass over both rule memories
// holds busy high. Results cannot be stalled by the receiver.
module packet_rule_classifier #(
    parameter int SERVICE_ENTRIES = 64,
    parameter int HOST_ENTRIES    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [5:0]  i_entry_index,
    input  logic        i_rule_valid,
    input  logic [1:0]  i_rule_class,
    input  logic        i_rule_outgoing,
    input  logic [7:0]  i_protocol,
    input  logic [15:0] i_port,
    input  logic [15:0] i_port_high,
    input  logic [31:0] i_address,
    input  logic [5:0]  i_prefix_len,
    input  logic        i_no_ports,
    output logic        o_done,
    output logic [1:0]  o_verdict
);

    logic          back_init;
    logic          q_full;
    logic          q_not_empty;
    logic          push;
    logic          pop;
    prc_pkg::t_cmd front_cmd;
    prc_pkg::t_cmd queue_cmd;

    // Front end: accepts and decodes each transaction.
    prc_front #(
        .SERVICE_ENTRIES (SERVICE_ENTRIES),
        .HOST_ENTRIES    (HOST_ENTRIES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_entry_index   (i_entry_index),
        .i_rule_valid    (i_rule_valid),
        .i_rule_class    (i_rule_class),
        .i_rule_outgoing (i_rule_outgoing),
        .i_protocol      (i_protocol),
        .i_port          (i_port),
        .i_port_high     (i_port_high),
        .i_address       (i_address),
        .i_prefix_len    (i_prefix_len),
        .i_no_ports      (i_no_ports),
        .i_back_init     (back_init),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    // Command queue decoupling the two ends.
    prc_cmd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (front_cmd),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_cmd       (queue_cmd)
    );

    // Back end: rule memories, scans and verdicts.
    prc_back #(
        .SERVICE_ENTRIES (SERVICE_ENTRIES),
        .HOST_ENTRIES    (HOST_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (q_not_empty),
        .i_cmd     (queue_cmd),
        .o_pop     (pop),
        .o_init    (back_init),
        .o_done    (o_done),
        .o_verdict (o_verdict)
    );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import prc_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int SVC_DEPTH      = 64;
    localparam int HOST_DEPTH     = 32;
    localparam int HOST_IW        = $clog2(HOST_DEPTH);
    localparam int RANDOM_ITEMS   = 1200;
    localparam int CALM_ITEMS     = 200;
    localparam int TAIL_CYCLES    = SVC_DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 2000;

    // One command transaction as presented on the input ports.
    typedef struct {
        logic [2:0]  opcode;
        logic [5:0]  entry_index;
        logic        rule_valid;
        logic [1:0]  rule_class;
        logic        rule_outgoing;
        logic [7:0]  protocol;
        logic [15:0] port;
        logic [15:0] port_high;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic        no_ports;
    } t_txn;

    // Shadow copy of both rule tables; predicts one verdict per command.
    class verdict_scoreboard;
        t_svc_entry  svc_tbl[SVC_DEPTH];
        t_host_entry host_tbl[HOST_DEPTH];
        logic [1:0]  exp_verdicts[$];
        int          mismatches;
        int          verdicts_checked;

        function new();
            clear_tables();
            mismatches       = 0;
            verdicts_checked = 0;
        endfunction

        function void clear_tables();
            foreach (svc_tbl[i]) svc_tbl[i] = '0;
            foreach (host_tbl[i]) host_tbl[i] = '0;
        endfunction

        function void report_error(string msg);
            $display("%0t: %s", $time, msg);
            mismatches++;
        endfunction

        // Set of rule classes whose service entries match the packet.
        function logic [3:0] svc_hits(logic outgoing, logic [7:0] proto, logic [15:0] port);
            logic [3:0] hits;
            hits = '0;
            foreach (svc_tbl[i]) begin
                if (svc_tbl[i].valid && svc_tbl[i].outgoing == outgoing &&
                    svc_tbl[i].proto == proto &&
                    port >= svc_tbl[i].lo && port <= svc_tbl[i].hi)
                    hits[svc_tbl[i].cls] = 1'b1;
            end
            return hits;
        endfunction

        // Set of rule classes whose host prefixes cover the address.
        function logic [3:0] host_hits(logic [31:0] addr);
            logic [3:0]  hits;
            logic [31:0] mask;
            hits = '0;
            foreach (host_tbl[i]) begin
                if (host_tbl[i].plen == 0)
                    mask = '0;
                else
                    mask = ADDR_ONES << (ADDR_BITS - int'(host_tbl[i].plen));
                if (host_tbl[i].valid && (addr & mask) == (host_tbl[i].address & mask))
                    hits[host_tbl[i].cls] = 1'b1;
            end
            return hits;
        endfunction

        // Outgoing grading: deny drops, then allow beats warning beats alert.
        function logic [1:0] grade_outgoing(logic [3:0] hits);
            if (hits[CLS_DENY]) return VERD_DROP;
            if (hits[CLS_ALLOW]) return VERD_ALLOW;
            if (hits[CLS_WARNING]) return VERD_WARNING;
            if (hits[CLS_ALERT]) return VERD_ALERT;
            return VERD_DROP;
        endfunction

        // Apply an accepted command to the shadow tables and queue its verdict.
        function void note_command(t_txn c);
            logic [1:0] verdict;
            logic [3:0] hits;
            logic [1:0] host_grade;
            logic [1:0] svc_grade;
            verdict = VERD_DROP;
            case (c.opcode)
                OP_CLASSIFY_IN: begin
                    hits = svc_hits(1'b0, c.protocol, c.port);
                    if (hits[CLS_DENY]) verdict = VERD_DROP;
                    else if (hits[CLS_ALERT]) verdict = VERD_ALERT;
                    else if (hits[CLS_WARNING]) verdict = VERD_WARNING;
                    else if (hits[CLS_ALLOW]) verdict = VERD_ALLOW;
                end
                OP_CLASSIFY_OUT: begin
                    hits       = host_hits(c.address);
                    host_grade = grade_outgoing(hits);
                    if (hits[CLS_DENY] || c.no_ports) begin
                        verdict = host_grade;
                    end else begin
                        svc_grade = grade_outgoing(svc_hits(1'b1, c.protocol, c.port));
                        if (host_grade == VERD_DROP || svc_grade == VERD_DROP)
                            verdict = VERD_DROP;
                        else
                            verdict = (host_grade > svc_grade) ? host_grade : svc_grade;
                    end
                end
                OP_WRITE_SVC: begin
                    svc_tbl[c.entry_index] = '{valid: c.rule_valid, outgoing: c.rule_outgoing,
                                               cls: c.rule_class, proto: c.protocol,
                                               lo: c.port, hi: c.port_high};
                end
                OP_WRITE_HOST: begin
                    // Entries past the host table depth are silently dropped.
                    if (c.entry_index < HOST_DEPTH)
                        host_tbl[c.entry_index[HOST_IW-1:0]] = '{valid: c.rule_valid,
                            cls: c.rule_class, address: c.address,
                            plen: (c.prefix_len > PLEN_MAX) ? PLEN_MAX : c.prefix_len};
                end
                OP_CLEAR: begin
                    clear_tables();
                end
                default: begin
                end
            endcase
            exp_verdicts.push_back(verdict);
        endfunction

        // Compare one verdict strobe with the oldest expectation.
        function void check_verdict(logic [1:0] actual);
            logic [1:0] expected;
            verdicts_checked++;
            if (exp_verdicts.size() == 0) begin
                report_error($sformatf("unexpected verdict: expected none, actual %0d",
                                       actual));
                return;
            end
            expected = exp_verdicts.pop_front();
            if (actual !== expected)
                report_error($sformatf("verdict mismatch: expected %0d, actual %0d",
                                       expected, actual));
        endfunction

        function int pending();
            return exp_verdicts.size();
        endfunction

        function void flush_leftovers();
            while (exp_verdicts.size() != 0)
                report_error($sformatf("missing verdict: expected %0d, actual none",
                                       exp_verdicts.pop_front()));
        endfunction
    endclass

    // Clock, reset and block inputs, all known from time zero.
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic [2:0]  i_opcode        = '0;
    logic [5:0]  i_entry_index   = '0;
    logic        i_rule_valid    = 1'b0;
    logic [1:0]  i_rule_class    = '0;
    logic        i_rule_outgoing = 1'b0;
    logic [7:0]  i_protocol      = '0;
    logic [15:0] i_port          = '0;
    logic [15:0] i_port_high     = '0;
    logic [31:0] i_address       = '0;
    logic [5:0]  i_prefix_len    = '0;
    logic        i_no_ports      = 1'b0;
    logic        busy;
    logic        o_done;
    logic [1:0]  o_verdict;

    verdict_scoreboard sb;
    int                op_count[8];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    packet_rule_classifier #(
        .SERVICE_ENTRIES(SVC_DEPTH),
        .HOST_ENTRIES   (HOST_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_entry_index  (i_entry_index),
        .i_rule_valid   (i_rule_valid),
        .i_rule_class   (i_rule_class),
        .i_rule_outgoing(i_rule_outgoing),
        .i_protocol     (i_protocol),
        .i_port         (i_port),
        .i_port_high    (i_port_high),
        .i_address      (i_address),
        .i_prefix_len   (i_prefix_len),
        .i_no_ports     (i_no_ports),
        .o_done         (o_done),
        .o_verdict      (o_verdict)
    );

    // Every verdict strobe is taken at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            sb.check_verdict(o_verdict);
    end

    // Present one transaction and hold it until the block takes it.
    task automatic issue(input t_txn c);
        start           <= 1'b1;
        i_opcode        <= c.opcode;
        i_entry_index   <= c.entry_index;
        i_rule_valid    <= c.rule_valid;
        i_rule_class    <= c.rule_class;
        i_rule_outgoing <= c.rule_outgoing;
        i_protocol      <= c.protocol;
        i_port          <= c.port;
        i_port_high     <= c.port_high;
        i_address       <= c.address;
        i_prefix_len    <= c.prefix_len;
        i_no_ports      <= c.no_ports;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_command(c);
        op_count[c.opcode]++;
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending and wait until every queued verdict has come back.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Fields that a command does not use are filled with noise.
    function automatic t_txn random_fields();
        t_txn c;
        c.opcode        = 3'($urandom);
        c.entry_index   = 6'($urandom);
        c.rule_valid    = 1'($urandom);
        c.rule_class    = 2'($urandom);
        c.rule_outgoing = 1'($urandom);
        c.protocol      = 8'($urandom);
        c.port          = 16'($urandom);
        c.port_high     = 16'($urandom);
        c.address       = $urandom;
        c.prefix_len    = 6'($urandom);
        c.no_ports      = 1'($urandom);
        return c;
    endfunction

    function automatic t_txn svc_rule(logic [5:0] idx, logic valid, logic [1:0] cls,
                                      logic outgoing, logic [7:0] proto,
                                      logic [15:0] lo, logic [15:0] hi);
        t_txn c;
        c               = random_fields();
        c.opcode        = OP_WRITE_SVC;
        c.entry_index   = idx;
        c.rule_valid    = valid;
        c.rule_class    = cls;
        c.rule_outgoing = outgoing;
        c.protocol      = proto;
        c.port          = lo;
        c.port_high     = hi;
        return c;
    endfunction

    function automatic t_txn host_rule(logic [5:0] idx, logic valid, logic [1:0] cls,
                                       logic [31:0] addr, logic [5:0] plen);
        t_txn c;
        c             = random_fields();
        c.opcode      = OP_WRITE_HOST;
        c.entry_index = idx;
        c.rule_valid  = valid;
        c.rule_class  = cls;
        c.address     = addr;
        c.prefix_len  = plen;
        return c;
    endfunction

    function automatic t_txn classify(logic [2:0] op, logic [7:0] proto, logic [15:0] port,
                                      logic [31:0] addr, logic no_ports);
        t_txn c;
        c          = random_fields();
        c.opcode   = op;
        c.protocol = proto;
        c.port     = port;
        c.address  = addr;
        c.no_ports = no_ports;
        return c;
    endfunction

    function automatic t_txn bare(logic [2:0] op);
        t_txn c;
        c        = random_fields();
        c.opcode = op;
        return c;
    endfunction

    // Protocols, ports and addresses drawn from small pools so that rules hit often.
    function automatic logic [7:0] pick_proto();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'd6;
        if (r < 65) return 8'd17;
        if (r < 80) return 8'd1;
        if (r < 90) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] pick_port();
        if ($urandom_range(0, 99) < 75)
            return 16'($urandom_range(0, 1100));
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_addr();
        logic [7:0] net;
        case ($urandom_range(0, 4))
            0: net = 8'd10;
            1: net = 8'd172;
            2: net = 8'd192;
            3: net = 8'hFF;
            default: return $urandom;
        endcase
        return {net, 8'($urandom_range(0, 3)), 16'($urandom)};
    endfunction

    function automatic logic [5:0] pick_plen();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 6'($urandom_range(1, 4) * 8);
        if (r < 90) return 6'($urandom_range(0, 32));
        return 6'($urandom_range(33, 63));
    endfunction

    function automatic logic [1:0] pick_class();
        if ($urandom_range(0, 99) < 15)
            return CLS_DENY;
        return 2'($urandom_range(0, 2));
    endfunction

    // Random command mix: mostly classifies against a table that fills up
    // over time and is emptied by an occasional clear.
    function automatic t_txn rand_command();
        t_txn        c;
        int          pick;
        logic [15:0] lo;
        logic [15:0] hi;
        logic        valid;
        pick  = $urandom_range(0, 199);
        valid = ($urandom_range(0, 9) != 0);
        if (pick < 70) begin
            c = classify(OP_CLASSIFY_IN, pick_proto(), pick_port(), pick_addr(),
                         1'($urandom));
        end else if (pick < 140) begin
            c = classify(OP_CLASSIFY_OUT, pick_proto(), pick_port(), pick_addr(),
                         ($urandom_range(0, 9) < 3));
        end else if (pick < 165) begin
            lo = pick_port();
            case ($urandom_range(0, 6))
                0: hi = 16'hFFFF;
                1: hi = 16'($urandom);
                default: hi = (lo > 16'hFFFF - 300) ? 16'hFFFF
                                                    : lo + 16'($urandom_range(0, 300));
            endcase
            c = svc_rule(6'($urandom), valid, pick_class(), 1'($urandom), pick_proto(),
                         lo, hi);
        end else if (pick < 190) begin
            c = host_rule(6'($urandom_range(0, 9) == 0 ? $urandom_range(HOST_DEPTH, 63)
                                                       : $urandom_range(0, HOST_DEPTH - 1)),
                          valid, pick_class(), pick_addr(), pick_plen());
        end else if (pick < 192) begin
            c = bare(OP_CLEAR);
        end else begin
            c = bare(3'($urandom_range(OP_CLEAR + 1, 7)));
        end
        return c;
    endfunction

    // Give up if neither side moves a transaction for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** packet_rule_classifier: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int idle_pct;
        sb       = new();
        idle_pct = 0;
        foreach (op_count[i]) op_count[i] = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed rules: exact port, full range, inverted range, top entries,
        // an inactive entry, host bits in the rule address, a catch-all prefix,
        // an oversized prefix and a host write past the table depth.
        issue(svc_rule(0, 1'b1, CLS_ALLOW, 1'b0, 6, 80, 80));
        issue(svc_rule(1, 1'b1, CLS_WARNING, 1'b0, 6, 0, 16'hFFFF));
        issue(svc_rule(2, 1'b1, CLS_DENY, 1'b0, 17, 53, 53));
        issue(svc_rule(3, 1'b1, CLS_ALERT, 1'b0, 6, 100, 50));
        issue(svc_rule(62, 1'b1, CLS_ALLOW, 1'b1, 6, 0, 1023));
        issue(svc_rule(63, 1'b1, CLS_ALERT, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF));
        issue(svc_rule(5, 1'b0, CLS_DENY, 1'b0, 6, 80, 80));
        issue(host_rule(0, 1'b1, CLS_ALLOW, 32'h0A123456, 8));
        issue(host_rule(1, 1'b1, CLS_DENY, 32'hC0A80101, PLEN_MAX));
        issue(host_rule(2, 1'b1, CLS_ALERT, 32'h12345678, 0));
        issue(host_rule(HOST_DEPTH - 1, 1'b1, CLS_WARNING, ADDR_ONES, 6'd63));
        issue(host_rule(40, 1'b1, CLS_DENY, 32'h0, 0));

        // Directed lookups against those rules.
        issue(classify(OP_CLASSIFY_IN, 6, 80, 32'h0, 1'b0));
        issue(classify(OP_CLASSIFY_IN, 6, 75, ADDR_ONES, 1'b1));
        issue(classify(OP_CLASSIFY_IN, 17, 53, 32'h0, 1'b0));
        issue(classify(OP_CLASSIFY_OUT, 6, 80, 32'h0A000001, 1'b1));
        issue(classify(OP_CLASSIFY_OUT, 6, 1023, 32'h0A000001, 1'b0));
        issue(classify(OP_CLASSIFY_OUT, 8'hFF, 16'hFFFF, ADDR_ONES, 1'b0));
        issue(classify(OP_CLASSIFY_OUT, 6, 80, 32'hC0A80101, 1'b0));
        for (int op = OP_CLEAR + 1; op < 8; op++)
            issue(bare(3'(op)));
        issue(bare(OP_CLEAR));
        issue(classify(OP_CLASSIFY_OUT, 6, 80, 32'h0A000001, 1'b0));
        issue(classify(OP_CLASSIFY_IN, 6, 80, 32'h0, 1'b0));

        // Random traffic with sender idling that changes every 50 transactions
        // and stops for the last stretch.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 50;
                endcase
            end
            if (n == RANDOM_ITEMS / 2) begin
                drain();
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            issue(rand_command());
            if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 99) < idle_pct)
                pause_sender($urandom_range(1, 18));
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.flush_leftovers();

        $display("Run covered %0d inbound and %0d outbound classifies, %0d service and %0d host",
                 op_count[OP_CLASSIFY_IN], op_count[OP_CLASSIFY_OUT],
                 op_count[OP_WRITE_SVC], op_count[OP_WRITE_HOST]);
        $display("rule writes, %0d clears, %0d unused opcodes; %0d verdicts checked, %0d errors.",
                 op_count[OP_CLEAR], op_count[5] + op_count[6] + op_count[7],
                 sb.verdicts_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("** packet_rule_classifier: PASSED **");
        else
            $display("** packet_rule_classifier: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
hdl/prc_pkg.sv
hdl/prc_front.sv
hdl/prc_cmd_queue.sv
hdl/prc_back.sv
hdl/packet_rule_classifier.sv
dv/tb_top.sv
